// ===== rtl/thread_busy_depth_hash_table_defines.svh =====
// ---------------------------------------------------------------------------
// thread_busy_depth_hash_table_defines.svh
// assertion macros for the busy-depth hash table
// ---------------------------------------------------------------------------
`ifndef THREAD_BUSY_DEPTH_HASH_TABLE_DEFINES_SVH
`define THREAD_BUSY_DEPTH_HASH_TABLE_DEFINES_SVH

// same-cycle implication, checked out of reset
`define TBDHT_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked out of reset
`define TBDHT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/tbdht_pkg.sv =====
// ---------------------------------------------------------------------------
// tbdht_pkg
// shared types, constants and the saturating counter update
// ---------------------------------------------------------------------------
`default_nettype none

package tbdht_pkg;

  localparam int SLOTS_DEF  = 256;
  localparam int KEY_W      = 32;
  localparam int LEVEL_W    = 16;
  localparam int DELTA_W    = 8;
  localparam int SLOT_OUT_W = 8;
  localparam int HASH_W     = KEY_W - 2;
  localparam int HASH_STEP  = 3;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_HASH,
    ST_PROBE,
    ST_READ
  } state_t;

  typedef enum logic {
    MODE_UPDATE = 1'b0,
    MODE_QUERY  = 1'b1
  } mode_t;

  // counter plus signed delta, clamped to the 16-bit signed range
  function automatic logic signed [LEVEL_W-1:0] sat_add(
    input logic signed [LEVEL_W-1:0] base,
    input logic signed [DELTA_W-1:0] delta
  );
    logic signed [LEVEL_W:0] sum;
    logic signed [LEVEL_W-1:0] res;
    sum = {base[LEVEL_W-1], base} + {{(LEVEL_W+1-DELTA_W){delta[DELTA_W-1]}}, delta};
    if (sum[LEVEL_W] != sum[LEVEL_W-1]) begin
      res = sum[LEVEL_W] ? {1'b1, {(LEVEL_W-1){1'b0}}} : {1'b0, {(LEVEL_W-1){1'b1}}};
    end else begin
      res = sum[LEVEL_W-1:0];
    end
    return res;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/tbdht_ram.sv =====
// ---------------------------------------------------------------------------
// tbdht_ram
// simple dual-port synchronous ram, one write and one registered read port
// ---------------------------------------------------------------------------
`default_nettype none

module tbdht_ram #(
  parameter int WIDTH = tbdht_pkg::KEY_W,
  parameter int DEPTH = tbdht_pkg::SLOTS_DEF,
  localparam int AW   = $clog2(DEPTH)
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

// ===== rtl/tbdht_home.sv =====
// ---------------------------------------------------------------------------
// tbdht_home
// home slot of a key: (id >> 2) mod SLOTS, a mask for power-of-two sizes,
// otherwise a restoring remainder that takes STEP bits of the key per cycle
// ---------------------------------------------------------------------------
`default_nettype none

module tbdht_home #(
  parameter int SLOTS = tbdht_pkg::SLOTS_DEF,
  localparam int SW   = $clog2(SLOTS)
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          go,
  input  wire logic [tbdht_pkg::HASH_W-1:0]  key,
  output logic                               done,
  output logic [SW-1:0]                      home
);

  localparam bit POW2  = (SLOTS & (SLOTS - 1)) == 0;
  localparam int STEP  = tbdht_pkg::HASH_STEP;
  localparam int NSTEP = (tbdht_pkg::HASH_W + STEP - 1) / STEP;
  localparam int KW    = NSTEP * STEP;
  localparam int CW    = (NSTEP > 1) ? $clog2(NSTEP) : 1;

  logic          done_r;
  logic [SW-1:0] home_r;

  generate
    if (POW2) begin : g_mask
      // power of two: the low bits are the remainder
      always_ff @(posedge clk) begin
        if (!rst_n) begin
          done_r <= 1'b0;
        end else begin
          done_r <= go;
        end
      end

      always_ff @(posedge clk) begin
        if (go) begin
          home_r <= key[SW-1:0];
        end
      end
    end else begin : g_div
      logic          run_r;
      logic [CW-1:0] cnt_r;
      logic [KW-1:0] sh_r;
      logic [SW-1:0] rem_nxt;

      // STEP bits of the dividend per cycle, msb first
      always_comb begin
        logic [SW:0]   t;
        logic [SW-1:0] r;
        r = home_r;
        for (int j = 0; j < STEP; j++) begin
          t = {r, sh_r[KW-1-j]};
          if (t >= (SW+1)'(SLOTS)) begin
            t = t - (SW+1)'(SLOTS);
          end
          r = t[SW-1:0];
        end
        rem_nxt = r;
      end

      always_ff @(posedge clk) begin
        if (!rst_n) begin
          run_r  <= 1'b0;
          done_r <= 1'b0;
          cnt_r  <= '0;
        end else begin
          done_r <= 1'b0;
          if (go) begin
            run_r <= 1'b1;
            cnt_r <= '0;
          end else if (run_r) begin
            cnt_r <= cnt_r + 1'b1;
            if (cnt_r == CW'(NSTEP - 1)) begin
              run_r  <= 1'b0;
              done_r <= 1'b1;
            end
          end
        end
      end

      // partial remainder and shifting dividend
      always_ff @(posedge clk) begin
        if (go) begin
          home_r <= '0;
          sh_r   <= KW'(key);
        end else if (run_r) begin
          home_r <= rem_nxt;
          sh_r   <= sh_r << STEP;
        end
      end
    end
  endgenerate

  assign done = done_r;
  assign home = home_r;

endmodule

`default_nettype wire

// ===== rtl/thread_busy_depth_hash_table.sv =====
// ---------------------------------------------------------------------------
// thread_busy_depth_hash_table
// open-addressing table from thread id to a saturating busy-depth counter,
// linear probing from the home slot, keys and counters held in two rams
// ---------------------------------------------------------------------------
//
//   channel   ports                                      transfer when
//   input     in_mode, in_thread_id, in_delta            start && !busy
//   result    out_found, out_table_full, out_slot_index, out_strobe
//             out_busy_level
//
// - zero id: result in the cycle after the transfer, no table access
// - otherwise: home slot (a mask for a power-of-two SLOTS, else a remainder),
//   then slot after slot probed on the key ram read port, plus a read of
//   the counter ram when the id already sits in the table
// - after reset a clearing pass writes zero to every key with busy high;
//   counters need no pass, a newly claimed slot starts at zero
// - the result strobe lasts one cycle; the receiver cannot stall it
//
`default_nettype none

`include "thread_busy_depth_hash_table_defines.svh"

module thread_busy_depth_hash_table #(
  parameter int SLOTS = tbdht_pkg::SLOTS_DEF
) (
  input  wire logic                                  clk,
  input  wire logic                                  rst_n,
  input  wire logic                                  start,
  output logic                                       busy,
  input  wire logic                                  in_mode,
  input  wire logic [tbdht_pkg::KEY_W-1:0]           in_thread_id,
  input  wire logic signed [tbdht_pkg::DELTA_W-1:0]  in_delta,
  output logic                                       out_strobe,
  output logic                                       out_found,
  output logic                                       out_table_full,
  output logic [tbdht_pkg::SLOT_OUT_W-1:0]           out_slot_index,
  output logic signed [tbdht_pkg::LEVEL_W-1:0]       out_busy_level
);

  localparam int SW  = $clog2(SLOTS);
  localparam int KW  = tbdht_pkg::KEY_W;
  localparam int LW  = tbdht_pkg::LEVEL_W;
  localparam int DW  = tbdht_pkg::DELTA_W;
  localparam int OW  = tbdht_pkg::SLOT_OUT_W;

  tbdht_pkg::state_t state_r, state_nxt;

  logic                 accept;
  logic                 mode_r;
  logic [KW-1:0]        id_r;
  logic signed [DW-1:0] delta_r;
  logic [SW-1:0]        slot_r, slot_nxt;
  logic [SW-1:0]        cnt_r, cnt_nxt;
  logic [SW-1:0]        clr_r;

  logic                 out_strobe_r, out_strobe_nxt;
  logic                 out_found_r, out_found_nxt;
  logic                 out_full_r, out_full_nxt;
  logic [SW-1:0]        out_slot_r, out_slot_nxt;
  logic signed [LW-1:0] out_level_r, out_level_nxt;

  logic                 key_we;
  logic [SW-1:0]        key_waddr, key_raddr;
  logic [KW-1:0]        key_wdata, key_rdata;
  logic                 lvl_we;
  logic signed [LW-1:0] lvl_wdata, lvl_rdata;

  logic                 home_done;
  logic [SW-1:0]        home;
  logic [SW-1:0]        slot_inc;
  logic [SW+OW-1:0]     slot_ext;

  assign accept = start && !busy;
  assign busy   = (state_r != tbdht_pkg::ST_IDLE);

  // home slot unit, loaded straight from the input on a transfer
  tbdht_home #(
    .SLOTS (SLOTS)
  ) u_home (
    .clk   (clk),
    .rst_n (rst_n),
    .go    (accept && (in_thread_id != '0)),
    .key   (in_thread_id[KW-1:2]),
    .done  (home_done),
    .home  (home)
  );

  // key store
  tbdht_ram #(
    .WIDTH (KW),
    .DEPTH (SLOTS)
  ) u_key_ram (
    .clk   (clk),
    .we    (key_we),
    .waddr (key_waddr),
    .wdata (key_wdata),
    .raddr (key_raddr),
    .rdata (key_rdata)
  );

  // counter store, read at the current probe slot
  tbdht_ram #(
    .WIDTH (LW),
    .DEPTH (SLOTS)
  ) u_level_ram (
    .clk   (clk),
    .we    (lvl_we),
    .waddr (slot_r),
    .wdata (lvl_wdata),
    .raddr (slot_r),
    .rdata (lvl_rdata)
  );

  // next probe slot with wrap
  assign slot_inc = (slot_r == SW'(SLOTS - 1)) ? '0 : slot_r + 1'b1;

  // state register and control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= tbdht_pkg::ST_CLEAR;
      clr_r        <= '0;
      out_strobe_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      out_strobe_r <= out_strobe_nxt;
      if (state_r == tbdht_pkg::ST_CLEAR) begin
        clr_r <= clr_r + 1'b1;
      end
    end
  end

  // request and probe payload
  always_ff @(posedge clk) begin
    if (accept) begin
      mode_r  <= in_mode;
      id_r    <= in_thread_id;
      delta_r <= in_delta;
    end
    slot_r      <= slot_nxt;
    cnt_r       <= cnt_nxt;
    out_found_r <= out_found_nxt;
    out_full_r  <= out_full_nxt;
    out_slot_r  <= out_slot_nxt;
    out_level_r <= out_level_nxt;
  end

  // next state, ram accesses and result
  always_comb begin
    state_nxt      = state_r;
    slot_nxt       = slot_r;
    cnt_nxt        = cnt_r;
    key_we         = 1'b0;
    key_waddr      = slot_r;
    key_wdata      = id_r;
    key_raddr      = slot_r;
    lvl_we         = 1'b0;
    lvl_wdata      = tbdht_pkg::sat_add(lvl_rdata, delta_r);
    out_strobe_nxt = 1'b0;
    out_found_nxt  = 1'b0;
    out_full_nxt   = 1'b0;
    out_slot_nxt   = '0;
    out_level_nxt  = '0;

    unique case (state_r)
      tbdht_pkg::ST_CLEAR: begin
        key_we    = 1'b1;
        key_waddr = clr_r;
        key_wdata = '0;
        if (clr_r == SW'(SLOTS - 1)) begin
          state_nxt = tbdht_pkg::ST_IDLE;
        end
      end

      tbdht_pkg::ST_IDLE: begin
        if (accept) begin
          if (in_thread_id == '0) begin
            out_strobe_nxt = 1'b1;
          end else begin
            state_nxt = tbdht_pkg::ST_HASH;
          end
        end
      end

      // wait for the home slot, then read its key
      tbdht_pkg::ST_HASH: begin
        if (home_done) begin
          key_raddr = home;
          slot_nxt  = home;
          cnt_nxt   = '0;
          state_nxt = tbdht_pkg::ST_PROBE;
        end
      end

      // key of slot_r is on the read port
      tbdht_pkg::ST_PROBE: begin
        priority if (key_rdata == id_r) begin
          state_nxt = tbdht_pkg::ST_READ;
        end else if (key_rdata == '0) begin
          state_nxt      = tbdht_pkg::ST_IDLE;
          out_strobe_nxt = 1'b1;
          if (mode_r == tbdht_pkg::MODE_UPDATE) begin
            // claim the empty slot, its counter starts from zero
            key_we        = 1'b1;
            lvl_we        = 1'b1;
            lvl_wdata     = tbdht_pkg::sat_add('0, delta_r);
            out_found_nxt = 1'b1;
            out_slot_nxt  = slot_r;
            out_level_nxt = lvl_wdata;
          end
        end else if (cnt_r == SW'(SLOTS - 1)) begin
          state_nxt      = tbdht_pkg::ST_IDLE;
          out_strobe_nxt = 1'b1;
          out_full_nxt   = (mode_r == tbdht_pkg::MODE_UPDATE);
        end else begin
          slot_nxt  = slot_inc;
          cnt_nxt   = cnt_r + 1'b1;
          key_raddr = slot_inc;
        end
      end

      // counter of the hit slot is on the read port
      tbdht_pkg::ST_READ: begin
        state_nxt      = tbdht_pkg::ST_IDLE;
        out_strobe_nxt = 1'b1;
        out_found_nxt  = 1'b1;
        out_slot_nxt   = slot_r;
        if (mode_r == tbdht_pkg::MODE_UPDATE) begin
          lvl_we        = 1'b1;
          out_level_nxt = lvl_wdata;
        end else begin
          out_level_nxt = lvl_rdata;
        end
      end

      default: begin
        state_nxt = tbdht_pkg::ST_IDLE;
      end
    endcase
  end

  // result ports
  assign slot_ext       = {{OW{1'b0}}, out_slot_r};
  assign out_strobe     = out_strobe_r;
  assign out_found      = out_found_r;
  assign out_table_full = out_full_r;
  assign out_slot_index = slot_ext[OW-1:0];
  assign out_busy_level = out_level_r;

  // checks
  `TBDHT_ASSERT_NOW(a_miss_zero, out_strobe && !out_found, (out_slot_r == '0) && (out_busy_level == '0), "miss result carries slot or level")
  `TBDHT_ASSERT_NOW(a_found_not_full, out_strobe, !(out_found && out_table_full), "found and table_full both set")
  `TBDHT_ASSERT_NOW(a_full_update, out_strobe && out_table_full, mode_r == tbdht_pkg::MODE_UPDATE, "table_full on a query")
  `TBDHT_ASSERT_NEXT(a_accept_next, accept, busy || out_strobe, "transfer neither started work nor answered")
  `TBDHT_ASSERT_NOW(a_strobe_cause, out_strobe, $past(busy) || $past(start), "result without a request")

endmodule

`default_nettype wire

// ===== bench/tb_thread_busy_depth_hash_table.sv =====
// ---------------------------------------------------------------------------
// tb_thread_busy_depth_hash_table
// self-checking bench for the busy-depth hash table: a directed opening,
// then random traffic that reuses ids, clusters home slots near the wrap,
// ramps two hot counters into saturation, fills the table and runs more random traffic on it;
// every result is compared field by field with a mirrored table
// ---------------------------------------------------------------------------
module tb_thread_busy_depth_hash_table;

  localparam int NUM_SLOTS   = tbdht_pkg::SLOTS_DEF;
  localparam int KEY_W       = tbdht_pkg::KEY_W;
  localparam int DELTA_W     = tbdht_pkg::DELTA_W;
  localparam int LEVEL_W     = tbdht_pkg::LEVEL_W;
  localparam int SLOT_OUT_W  = tbdht_pkg::SLOT_OUT_W;
  localparam int STALL_LIMIT = 4000;
  localparam int TAIL_CYCLES = 300;
  localparam int HOT_FLIP    = 280;

  // one table operation as the sender sees it
  typedef struct {
    tbdht_pkg::mode_t          mode;
    logic [KEY_W-1:0]          id;
    logic signed [DELTA_W-1:0] delta;
    bit                        drain;
  } thread_op_t;

  // one expected table response
  typedef struct {
    logic                      found;
    logic                      full;
    logic [SLOT_OUT_W-1:0]     slot;
    logic signed [LEVEL_W-1:0] level;
  } busy_result_t;

  logic                      clk = 1'b0;
  logic                      rst_n = 1'b0;
  logic                      start = 1'b0;
  logic                      busy;
  logic                      in_mode = 1'b0;
  logic [KEY_W-1:0]          in_thread_id = '0;
  logic signed [DELTA_W-1:0] in_delta = '0;
  logic                      out_strobe;
  logic                      out_found;
  logic                      out_table_full;
  logic [SLOT_OUT_W-1:0]     out_slot_index;
  logic signed [LEVEL_W-1:0] out_busy_level;

  thread_op_t   op_queue[$];
  busy_result_t busy_expect_q[$];

  // mirrored table contents
  logic [KEY_W-1:0]          key_slots [NUM_SLOTS];
  logic signed [LEVEL_W-1:0] depth_slots [NUM_SLOTS];

  // generator bookkeeping: ids that will sit in the table
  bit               in_table [logic [KEY_W-1:0]];
  logic [KEY_W-1:0] known_ids[$];
  int               hot_updates [2];
  logic [KEY_W-1:0] hot_ids [2] = '{32'h1000_0001, 32'hDEAD_BEE8};

  thread_op_t  cur_op;
  int unsigned issued_cnt = 0;
  int unsigned accepted_cnt = 0;
  int unsigned total_ops = 0;
  int unsigned phase_a_end = 0;
  int unsigned phase_b_end = 0;
  int unsigned stall_cycles = 0;
  int unsigned mismatch_cnt = 0;

  thread_busy_depth_hash_table u_top (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_mode        (in_mode),
    .in_thread_id   (in_thread_id),
    .in_delta       (in_delta),
    .out_strobe     (out_strobe),
    .out_found      (out_found),
    .out_table_full (out_table_full),
    .out_slot_index (out_slot_index),
    .out_busy_level (out_busy_level)
  );

  always #4 clk = ~clk;

  // mismatch reporting
  task automatic report_mismatch(input string field, input longint got,
                                 input longint want);
    mismatch_cnt++;
    $display("mismatch %s: got %0d want %0d (after %0d transfers)",
             field, got, want, accepted_cnt);
  endtask

  // linear probe on the mirrored table, queues the expected response
  task automatic predict_busy_result(input thread_op_t op);
    busy_result_t r;
    int unsigned  home;
    int unsigned  s;
    int           sum;
    bit           hit;
    bit           stop;
    r = '{found: 1'b0, full: 1'b0, slot: '0, level: '0};
    hit = 1'b0;
    stop = 1'b0;
    s = 0;
    if (op.id != '0) begin
      home = (op.id >> 2) % NUM_SLOTS;
      for (int i = 0; i < NUM_SLOTS && !stop; i++) begin
        s = (home + i) % NUM_SLOTS;
        if (key_slots[s] == op.id) begin
          hit = 1'b1;
          stop = 1'b1;
        end else if (key_slots[s] == '0) begin
          stop = 1'b1;
          // an update claims the first empty slot
          if (op.mode == tbdht_pkg::MODE_UPDATE) begin
            key_slots[s] = op.id;
            depth_slots[s] = '0;
            hit = 1'b1;
          end
        end
      end
      if (hit) begin
        if (op.mode == tbdht_pkg::MODE_UPDATE) begin
          sum = int'(depth_slots[s]) + int'(op.delta);
          if (sum > 32767) sum = 32767;
          if (sum < -32768) sum = -32768;
          depth_slots[s] = 16'(sum);
        end
        r.found = 1'b1;
        r.slot = 8'(s);
        r.level = depth_slots[s];
      end else if (!stop && op.mode == tbdht_pkg::MODE_UPDATE) begin
        // whole table walked without a match or a free slot
        r.full = 1'b1;
      end
    end
    busy_expect_q.push_back(r);
  endtask

  // queue one operation and track which ids end up in the table
  task automatic add_op(input tbdht_pkg::mode_t mode, input logic [KEY_W-1:0] id,
                        input logic signed [DELTA_W-1:0] delta, input bit drain);
    thread_op_t op;
    op = '{mode: mode, id: id, delta: delta, drain: drain};
    op_queue.push_back(op);
    if (mode == tbdht_pkg::MODE_UPDATE && id != '0 && !in_table.exists(id) &&
        known_ids.size() < NUM_SLOTS) begin
      in_table[id] = 1'b1;
      known_ids.push_back(id);
    end
  endtask

  // id not yet in the table, half of them homed near the wrap point
  function automatic logic [KEY_W-1:0] fresh_id();
    logic [KEY_W-1:0] id;
    do begin
      id = $urandom;
      if ($urandom_range(1) == 1) id[9:2] = 8'hF0 + 8'($urandom_range(15));
    end while (id == '0 || in_table.exists(id));
    return id;
  endfunction

  // one random operation; hot ids ramp their counters toward saturation
  task automatic add_mixed_op(input int hot_pct);
    int               c;
    int               idx;
    bit               neg;
    bit               drain;
    logic [KEY_W-1:0] id;
    drain = ($urandom_range(99) == 0);
    if ($urandom_range(99) < hot_pct) begin
      idx = $urandom_range(1);
      neg = (((hot_updates[idx] / HOT_FLIP) % 2) == 0) ^ (idx == 1);
      hot_updates[idx]++;
      if (neg) begin
        add_op(tbdht_pkg::MODE_UPDATE, hot_ids[idx], 8'(-$urandom_range(118, 128)),
               drain);
      end else begin
        add_op(tbdht_pkg::MODE_UPDATE, hot_ids[idx], 8'($urandom_range(118, 127)),
               drain);
      end
    end else begin
      c = $urandom_range(99);
      id = known_ids[$urandom_range(known_ids.size() - 1)];
      if (c < 8) begin
        add_op(tbdht_pkg::mode_t'($urandom_range(1)), '0, 8'($urandom), drain);
      end else if (c < 30) begin
        add_op(tbdht_pkg::MODE_QUERY, id, 8'($urandom), drain);
      end else if (c < 42) begin
        add_op(tbdht_pkg::MODE_QUERY, $urandom, 8'($urandom), drain);
      end else if (c < 70) begin
        add_op(tbdht_pkg::MODE_UPDATE, id, 8'($urandom), drain);
      end else begin
        add_op(tbdht_pkg::MODE_UPDATE, fresh_id(), 8'($urandom), drain);
      end
    end
  endtask

  // driver: hold an operation until its transfer, then load the next one
  always @(posedge clk) begin : drive_ops
    int idle_pct;
    if (!rst_n) begin
      start <= 1'b0;
      in_mode <= tbdht_pkg::MODE_UPDATE;
      in_thread_id <= '0;
      in_delta <= '0;
    end else begin
      if (start && !busy) begin
        predict_busy_result(cur_op);
        accepted_cnt++;
      end
      idle_pct = (issued_cnt < phase_a_end) ? 13 : (issued_cnt < phase_b_end) ? 54 : 0;
      if (!start || !busy) begin
        if (op_queue.size() != 0 && $urandom_range(99) >= idle_pct &&
            !(op_queue[0].drain && busy_expect_q.size() != 0)) begin
          cur_op = op_queue.pop_front();
          start <= 1'b1;
          in_mode <= cur_op.mode;
          in_thread_id <= cur_op.id;
          in_delta <= cur_op.delta;
          issued_cnt++;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // monitor: compare each strobed result with the oldest expectation
  always @(posedge clk) begin : check_results
    busy_result_t want;
    if (rst_n && out_strobe) begin
      if (busy_expect_q.size() == 0) begin
        report_mismatch("result with nothing pending", 1, 0);
      end else begin
        want = busy_expect_q.pop_front();
        if (out_found !== want.found) report_mismatch("found", out_found, want.found);
        if (out_table_full !== want.full)
          report_mismatch("table_full", out_table_full, want.full);
        if (out_slot_index !== want.slot)
          report_mismatch("slot_index", out_slot_index, want.slot);
        if (out_busy_level !== want.level)
          report_mismatch("busy_level", out_busy_level, want.level);
      end
    end
  end

  // cycles since the last transfer on either side
  always @(posedge clk) begin
    if ((start && !busy) || out_strobe) stall_cycles <= 0;
    else stall_cycles <= stall_cycles + 1;
  end

  initial begin
    for (int i = 0; i < NUM_SLOTS; i++) begin
      key_slots[i] = '0;
      depth_slots[i] = '0;
    end
    hot_updates = '{0, 0};

    // directed: empty table, zero id, wrap at the top slot, probe chains
    add_op(tbdht_pkg::MODE_QUERY, 32'h0000_0001, 8'sd5, 1'b0);
    add_op(tbdht_pkg::MODE_UPDATE, 32'h0000_0000, 8'sd127, 1'b0);
    add_op(tbdht_pkg::MODE_QUERY, 32'h0000_0000, -8'sd128, 1'b0);
    add_op(tbdht_pkg::MODE_UPDATE, 32'hFFFF_FFFF, 8'sd127, 1'b0);
    add_op(tbdht_pkg::MODE_UPDATE, 32'hFFFF_FFFE, -8'sd128, 1'b0);
    add_op(tbdht_pkg::MODE_UPDATE, 32'hFFFF_FFFD, 8'sd1, 1'b0);
    add_op(tbdht_pkg::MODE_QUERY, 32'hFFFF_FFFE, 8'sd0, 1'b0);
    add_op(tbdht_pkg::MODE_UPDATE, 32'h0000_0004, -8'sd1, 1'b0);
    add_op(tbdht_pkg::MODE_UPDATE, 32'h0000_0001, 8'sd0, 1'b0);
    add_op(tbdht_pkg::MODE_UPDATE, 32'hFFFF_FFFF, 8'sd127, 1'b0);
    add_op(tbdht_pkg::MODE_UPDATE, 32'hFFFF_FFFF, -8'sd128, 1'b0);
    add_op(tbdht_pkg::MODE_QUERY, 32'h8000_0000, 8'sd0, 1'b1);
    add_op(tbdht_pkg::MODE_UPDATE, 32'h8000_0000, 8'sd127, 1'b0);
    add_op(tbdht_pkg::MODE_UPDATE, 32'h7FFF_FFFF, -8'sd128, 1'b0);
    add_op(tbdht_pkg::MODE_QUERY, 32'h7FFF_FFFF, 8'sd127, 1'b0);
    add_op(tbdht_pkg::MODE_QUERY, 32'h0000_0004, -8'sd128, 1'b0);
    add_op(tbdht_pkg::MODE_UPDATE, 32'h0000_0003, -8'sd128, 1'b0);
    add_op(tbdht_pkg::MODE_UPDATE, 32'h0000_0003, -8'sd128, 1'b0);
    add_op(tbdht_pkg::MODE_QUERY, 32'h0000_0002, 8'sd0, 1'b0);

    // random mix on a lightly loaded table
    for (int i = 0; i < 900; i++) add_mixed_op(55);
    // fill every remaining slot
    add_op(tbdht_pkg::MODE_UPDATE, fresh_id(), 8'($urandom), 1'b1);
    while (known_ids.size() < NUM_SLOTS) begin
      add_op(tbdht_pkg::MODE_UPDATE, fresh_id(), 8'($urandom), 1'b0);
    end
    // full table: misses walk every slot
    add_op(tbdht_pkg::MODE_UPDATE, fresh_id(), 8'($urandom), 1'b1);
    for (int i = 0; i < 300; i++) add_mixed_op(30);

    total_ops = op_queue.size();
    phase_a_end = total_ops / 3;
    phase_b_end = 2 * total_ops / 3;

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    while (!(accepted_cnt == total_ops && busy_expect_q.size() == 0) &&
           stall_cycles < STALL_LIMIT) @(posedge clk);
    if (stall_cycles < STALL_LIMIT) repeat (TAIL_CYCLES) @(posedge clk);

    if (stall_cycles >= STALL_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
    end else if (mismatch_cnt == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
